### design/rpwdr_pkg.sv
// ----------------------------------------------------------------------------
// rpwdr_pkg
// shared types and constants of the rotated pixel writer with dirty rectangle
// ----------------------------------------------------------------------------
package rpwdr_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 512;

   localparam int X_W      = $clog2(MAX_WIDTH);
   localparam int Y_W      = $clog2(MAX_HEIGHT);
   localparam int EW       = $clog2(MAX_WIDTH + 1);
   localparam int EH       = $clog2(MAX_HEIGHT + 1);
   localparam int FB_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW       = $clog2(FB_DEPTH);

   localparam int PIX_W    = 16;
   localparam int COORD_W  = 16;
   localparam int COLOR_W  = 8;
   localparam int PW_W     = 11;
   localparam int PH_W     = 10;
   localparam int ROT_W    = 2;
   localparam int RECT_X_W = 10;
   localparam int RECT_Y_W = 9;
   localparam int RECT_W_W = 11;
   localparam int RECT_H_W = 10;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   // signed working width of the rotation arithmetic
   localparam int SW       = COORD_W + 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [CSR_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROTATION     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_X_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_X_END   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_Y_START = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CLIP_Y_END   = 3'd6;

   localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
   localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
   localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
   localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

   typedef enum logic [KIND_W-1:0] {
      KIND_DRAW  = 2'd0,
      KIND_FLUSH = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_STORED    = 3'd0,
      STATUS_CLIPPED   = 3'd1,
      STATUS_OUTSIDE   = 3'd2,
      STATUS_UNCHANGED = 3'd3,
      STATUS_DONE      = 3'd4
   } status_type;

   typedef struct packed {
      logic [PW_W-1:0]    panel_width;
      logic [PH_W-1:0]    panel_height;
      logic [ROT_W-1:0]   rotation;
      logic [COORD_W-1:0] clip_x_start;
      logic [COORD_W-1:0] clip_x_end;
      logic [COORD_W-1:0] clip_y_start;
      logic [COORD_W-1:0] clip_y_end;
   } cfg_type;

   typedef struct packed {
      kind_type         kind;
      logic             clipped;
      logic             in_panel;
      logic [X_W-1:0]   px;
      logic [Y_W-1:0]   py;
      logic [PIX_W-1:0] word;
      logic [AW-1:0]    addr;
   } job_type;

endpackage

### design/rotated_pixel_writer_dirty_rect_unit.sv
// ----------------------------------------------------------------------------
// rotated_pixel_writer_dirty_rect_unit
// framebuffer pixel writer with clip, rotation, rgb565 packing and dirty rect
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  type, pos_x, pos_y, red, green, blue
//   rsp      out        rsp_valid / rsp_stall  status, pixel_word, rect_*
//   csr      in         csr_wr_en              csr_index, csr_wdata
//
// a draw or read inside the panel reads the store in idle and finishes in wait
// (a changed draw writes it back there); clip, outside, flush and out-of-panel
// reads load the result straight from idle; a beat passes the front stage register
// and the queue before the back sees it; after reset the store is zeroed word by word with req_stall high
// a stalled result holds the back; the front keeps filling the 4-deep queue
// ----------------------------------------------------------------------------
module rotated_pixel_writer_dirty_rect_unit import rpwdr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [KIND_W-1:0]     req_type,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COLOR_W-1:0]    req_red,
   input  logic [COLOR_W-1:0]    req_green,
   input  logic [COLOR_W-1:0]    req_blue,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [PIX_W-1:0]      rsp_pixel_word,
   output logic                  rsp_rect_valid,
   output logic [RECT_X_W-1:0]   rsp_rect_x,
   output logic [RECT_Y_W-1:0]   rsp_rect_y,
   output logic [RECT_W_W-1:0]   rsp_rect_w,
   output logic [RECT_H_W-1:0]   rsp_rect_h
);

   cfg_type cfg_ff, cfg_in;
   logic    clearing;
   logic    q_full, q_push, q_pop, q_not_empty;
   job_type q_job, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_PANEL_WIDTH:  cfg_in.panel_width  = csr_wdata[PW_W-1:0];
            REG_PANEL_HEIGHT: cfg_in.panel_height = csr_wdata[PH_W-1:0];
            REG_ROTATION:     cfg_in.rotation     = csr_wdata[ROT_W-1:0];
            REG_CLIP_X_START: cfg_in.clip_x_start = csr_wdata[COORD_W-1:0];
            REG_CLIP_X_END:   cfg_in.clip_x_end   = csr_wdata[COORD_W-1:0];
            REG_CLIP_Y_START: cfg_in.clip_y_start = csr_wdata[COORD_W-1:0];
            REG_CLIP_Y_END:   cfg_in.clip_y_end   = csr_wdata[COORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.panel_width  <= PW_W'(800);
         cfg_ff.panel_height <= PH_W'(480);
         cfg_ff.rotation     <= ROT_0;
         cfg_ff.clip_x_start <= 16'h8000;
         cfg_ff.clip_x_end   <= 16'h7fff;
         cfg_ff.clip_y_start <= 16'h8000;
         cfg_ff.clip_y_end   <= 16'h7fff;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpwdr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .clearing  (clearing),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   rpwdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_job),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   rpwdr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .clearing       (clearing),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_pixel_word (rsp_pixel_word),
      .rsp_rect_valid (rsp_rect_valid),
      .rsp_rect_x     (rsp_rect_x),
      .rsp_rect_y     (rsp_rect_y),
      .rsp_rect_w     (rsp_rect_w),
      .rsp_rect_h     (rsp_rect_h)
   );

endmodule

### design/rpwdr_ram.sv
// ----------------------------------------------------------------------------
// rpwdr_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rpwdr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/rpwdr_front.sv
// ----------------------------------------------------------------------------
// rpwdr_front
// accepts request beats, clips, rotates, bounds-checks, packs and addresses
// ----------------------------------------------------------------------------
module rpwdr_front import rpwdr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                clearing,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_type,
   input  logic [COORD_W-1:0]  req_pos_x,
   input  logic [COORD_W-1:0]  req_pos_y,
   input  logic [COLOR_W-1:0]  req_red,
   input  logic [COLOR_W-1:0]  req_green,
   input  logic [COLOR_W-1:0]  req_blue,
   input  logic                q_full,
   output logic                q_push,
   output job_type             q_job
);

   logic             s1_valid_ff, s1_valid_in;
   job_type          s1_ff, s1_in;
   logic             accept;
   kind_type         kind;
   logic [EW-1:0]    eff_w;
   logic [EH-1:0]    eff_h;
   logic [SW-1:0]    x_s, y_s, pw_s, ph_s, rx, ry;
   logic [ROT_W-1:0] rot_sel;
   logic             clipped;

   assign kind = kind_type'(req_type);
   assign eff_w = (32'(cfg.panel_width) > MAX_WIDTH) ? EW'(MAX_WIDTH) : EW'(cfg.panel_width);
   assign eff_h = (32'(cfg.panel_height) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(cfg.panel_height);

   assign q_push    = s1_valid_ff && !q_full;
   assign req_stall = clearing || (s1_valid_ff && q_full);
   assign accept    = req_valid && !req_stall;

   assign x_s  = {{(SW-COORD_W){req_pos_x[COORD_W-1]}}, req_pos_x};
   assign y_s  = {{(SW-COORD_W){req_pos_y[COORD_W-1]}}, req_pos_y};
   assign pw_s = SW'(cfg.panel_width);
   assign ph_s = SW'(cfg.panel_height);

   assign clipped = ($signed(req_pos_x) <  $signed(cfg.clip_x_start)) ||
                    ($signed(req_pos_x) >= $signed(cfg.clip_x_end))   ||
                    ($signed(req_pos_y) <  $signed(cfg.clip_y_start)) ||
                    ($signed(req_pos_y) >= $signed(cfg.clip_y_end));

   assign rot_sel = (kind == KIND_READ) ? ROT_0 : cfg.rotation;

   always_comb begin
      case (rot_sel)
         ROT_90: begin
            rx = pw_s - y_s - SW'(1);
            ry = x_s;
         end
         ROT_180: begin
            rx = pw_s - x_s - SW'(1);
            ry = ph_s - y_s - SW'(1);
         end
         ROT_270: begin
            rx = y_s;
            ry = ph_s - x_s - SW'(1);
         end
         default: begin
            rx = x_s;
            ry = y_s;
         end
      endcase
   end

   always_comb begin
      s1_in          = s1_ff;
      s1_in.kind     = kind;
      s1_in.clipped  = (kind == KIND_DRAW) && clipped;
      s1_in.in_panel = !rx[SW-1] && !ry[SW-1] && (rx < SW'(eff_w)) && (ry < SW'(eff_h));
      s1_in.px       = rx[X_W-1:0];
      s1_in.py       = ry[Y_W-1:0];
      s1_in.word     = {req_green[4:2], req_blue[7:3], req_red[7:3], req_green[7:5]};
      s1_in.addr     = '0;
   end

   always_comb begin
      if (accept && kind != KIND_NONE) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      q_job      = s1_ff;
      q_job.addr = AW'(s1_ff.py) * AW'(eff_w) + AW'(s1_ff.px);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

endmodule

### design/rpwdr_queue.sv
// ----------------------------------------------------------------------------
// rpwdr_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module rpwdr_queue import rpwdr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head
);

   job_type        slot_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]   count_ff, count_in;

   assign full      = (count_ff == (QAW+1)'(QDEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QAW'(32'(wr_ptr_ff) + 1 == QDEPTH ? 0 : 32'(wr_ptr_ff) + 1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QAW'(32'(rd_ptr_ff) + 1 == QDEPTH ? 0 : 32'(rd_ptr_ff) + 1) : rd_ptr_ff;
      count_in  = count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/rpwdr_back.sv
// ----------------------------------------------------------------------------
// rpwdr_back
// frame store clearing and access, compare-and-write, dirty rectangle and result register
// ----------------------------------------------------------------------------
module rpwdr_back import rpwdr_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   output logic                clearing,
   input  logic                q_not_empty,
   input  job_type             q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [PIX_W-1:0]    rsp_pixel_word,
   output logic                rsp_rect_valid,
   output logic [RECT_X_W-1:0] rsp_rect_x,
   output logic [RECT_Y_W-1:0] rsp_rect_y,
   output logic [RECT_W_W-1:0] rsp_rect_w,
   output logic [RECT_H_W-1:0] rsp_rect_h
);

   typedef enum logic [2:0] {
      BACK_CLEAR = 3'b001,
      BACK_IDLE  = 3'b010,
      BACK_WAIT  = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [AW-1:0]       clear_cnt_ff, clear_cnt_in;
   job_type             cur_ff, cur_in;
   logic [PW_W-1:0]     low_x_ff, low_x_in;
   logic [PH_W-1:0]     low_y_ff, low_y_in;
   logic [X_W-1:0]      high_x_ff, high_x_in;
   logic [Y_W-1:0]      high_y_ff, high_y_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          status_ff, status_in;
   logic [PIX_W-1:0]    pixel_ff, pixel_in;
   logic                rect_valid_ff, rect_valid_in;
   logic [RECT_X_W-1:0] rect_x_ff, rect_x_in;
   logic [RECT_Y_W-1:0] rect_y_ff, rect_y_in;
   logic [RECT_W_W-1:0] rect_w_ff, rect_w_in;
   logic [RECT_H_W-1:0] rect_h_ff, rect_h_in;
   logic                res_load;

   logic                out_free;
   logic                clear_last;
   logic                flush_empty;
   logic                ram_en, ram_we;
   logic [AW-1:0]       ram_addr;
   logic [PIX_W-1:0]    ram_wdata, ram_rdata;

   rpwdr_ram #(
      .WIDTH (PIX_W),
      .DEPTH (FB_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign clear_last  = (clear_cnt_ff == AW'(FB_DEPTH - 1));
   assign clearing    = (state_ff == BACK_CLEAR);
   assign flush_empty = (low_x_ff > PW_W'(high_x_ff)) || (low_y_ff > PH_W'(high_y_ff));

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      cur_in        = cur_ff;
      low_x_in      = low_x_ff;
      low_y_in      = low_y_ff;
      high_x_in     = high_x_ff;
      high_y_in     = high_y_ff;
      q_pop         = 1'b0;
      ram_en        = 1'b0;
      ram_we        = 1'b0;
      ram_addr      = q_head.addr;
      ram_wdata     = cur_ff.word;
      res_load      = 1'b0;
      status_in     = STATUS_DONE;
      pixel_in      = '0;
      rect_valid_in = 1'b0;
      rect_x_in     = '0;
      rect_y_in     = '0;
      rect_w_in     = '0;
      rect_h_in     = '0;

      case (state_ff)
         BACK_CLEAR: begin
            ram_en       = 1'b1;
            ram_we       = 1'b1;
            ram_addr     = clear_cnt_ff;
            ram_wdata    = '0;
            clear_cnt_in = clear_cnt_ff + AW'(1);
            if (clear_last) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_IDLE: begin
            if (q_not_empty && out_free) begin
               q_pop = 1'b1;
               case (q_head.kind)
                  KIND_DRAW: begin
                     if (q_head.clipped) begin
                        res_load  = 1'b1;
                        status_in = STATUS_CLIPPED;
                     end else if (!q_head.in_panel) begin
                        res_load  = 1'b1;
                        status_in = STATUS_OUTSIDE;
                     end else begin
                        ram_en   = 1'b1;
                        cur_in   = q_head;
                        state_in = BACK_WAIT;
                     end
                  end
                  KIND_FLUSH: begin
                     res_load = 1'b1;
                     if (!flush_empty) begin
                        rect_valid_in = 1'b1;
                        rect_x_in     = RECT_X_W'(low_x_ff);
                        rect_y_in     = RECT_Y_W'(low_y_ff);
                        rect_w_in     = RECT_W_W'(PW_W'(high_x_ff) - low_x_ff + PW_W'(1));
                        rect_h_in     = RECT_H_W'(PH_W'(high_y_ff) - low_y_ff + PH_W'(1));
                        low_x_in      = cfg.panel_width;
                        low_y_in      = cfg.panel_height;
                        high_x_in     = '0;
                        high_y_in     = '0;
                     end
                  end
                  KIND_READ: begin
                     if (q_head.in_panel) begin
                        ram_en   = 1'b1;
                        cur_in   = q_head;
                        state_in = BACK_WAIT;
                     end else begin
                        res_load = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BACK_WAIT: begin
            ram_addr = cur_ff.addr;
            if (out_free) begin
               res_load = 1'b1;
               state_in = BACK_IDLE;
               if (cur_ff.kind == KIND_READ) begin
                  pixel_in = ram_rdata;
               end else if (ram_rdata == cur_ff.word) begin
                  status_in = STATUS_UNCHANGED;
               end else begin
                  status_in = STATUS_STORED;
                  ram_en    = 1'b1;
                  ram_we    = 1'b1;
                  if (PW_W'(cur_ff.px) < low_x_ff) begin
                     low_x_in = PW_W'(cur_ff.px);
                  end
                  if (PH_W'(cur_ff.py) < low_y_ff) begin
                     low_y_in = PH_W'(cur_ff.py);
                  end
                  if (cur_ff.px > high_x_ff) begin
                     high_x_in = cur_ff.px;
                  end
                  if (cur_ff.py > high_y_ff) begin
                     high_y_in = cur_ff.py;
                  end
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CLEAR;
         clear_cnt_ff <= '0;
         low_x_ff     <= '1;
         low_y_ff     <= '1;
         high_x_ff    <= '0;
         high_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         low_x_ff     <= low_x_in;
         low_y_ff     <= low_y_in;
         high_x_ff    <= high_x_in;
         high_y_ff    <= high_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (res_load) begin
         status_ff     <= status_in;
         pixel_ff      <= pixel_in;
         rect_valid_ff <= rect_valid_in;
         rect_x_ff     <= rect_x_in;
         rect_y_ff     <= rect_y_in;
         rect_w_ff     <= rect_w_in;
         rect_h_ff     <= rect_h_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_pixel_word = pixel_ff;
   assign rsp_rect_valid = rect_valid_ff;
   assign rsp_rect_x     = rect_x_ff;
   assign rsp_rect_y     = rect_y_ff;
   assign rsp_rect_w     = rect_w_ff;
   assign rsp_rect_h     = rect_h_ff;

   // no queue pop while a store access is open
   a_no_pop_in_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WAIT) |-> !q_pop)
      else $error("queue popped during store access");

   // clearing pass runs to its last word
   a_clear_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_CLEAR && !clear_last) |=> (state_ff == BACK_CLEAR))
      else $error("clearing pass ended early");

   // a stalled result keeps the store access open
   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WAIT && !out_free) |=> (state_ff == BACK_WAIT && $stable(cur_ff)))
      else $error("store access dropped under stall");

   // a stored pixel lies inside the watermarks
   a_marks_cover: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_WAIT && out_free && cur_ff.kind == KIND_DRAW &&
       ram_rdata != cur_ff.word)
      |=> (high_x_ff >= $past(cur_ff.px) && low_x_ff <= PW_W'($past(cur_ff.px)) &&
           high_y_ff >= $past(cur_ff.py) && low_y_ff <= PH_W'($past(cur_ff.py))))
      else $error("dirty rectangle misses a stored pixel");

endmodule

### tb/rotated_pixel_writer_dirty_rect_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_pixel_writer_dirty_rect_checker
// watches the csr, req and rsp ports of the pixel writer, keeps its own
// framebuffer, clip, rotation and dirty rectangle state, predicts one outcome
// per accepted draw, flush or read; every rsp beat is compared with the oldest one
// ----------------------------------------------------------------------------
module rotated_pixel_writer_dirty_rect_checker import rpwdr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [KIND_W-1:0]     req_type,
   input  logic [COORD_W-1:0]    req_pos_x,
   input  logic [COORD_W-1:0]    req_pos_y,
   input  logic [COLOR_W-1:0]    req_red,
   input  logic [COLOR_W-1:0]    req_green,
   input  logic [COLOR_W-1:0]    req_blue,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [PIX_W-1:0]      rsp_pixel_word,
   input  logic                  rsp_rect_valid,
   input  logic [RECT_X_W-1:0]   rsp_rect_x,
   input  logic [RECT_Y_W-1:0]   rsp_rect_y,
   input  logic [RECT_W_W-1:0]   rsp_rect_w,
   input  logic [RECT_H_W-1:0]   rsp_rect_h,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      status_type          status;
      logic [PIX_W-1:0]    pixel_word;
      logic                rect_valid;
      logic [RECT_X_W-1:0] rect_x;
      logic [RECT_Y_W-1:0] rect_y;
      logic [RECT_W_W-1:0] rect_w;
      logic [RECT_H_W-1:0] rect_h;
   } pixel_outcome_type;

   pixel_outcome_type outcome_q[$];

   logic [PIX_W-1:0] shadow_fb [int unsigned];

   logic [PW_W-1:0]     panel_w;
   logic [PH_W-1:0]     panel_h;
   logic [ROT_W-1:0]    rot;
   int                  clip_xs, clip_xe, clip_ys, clip_ye;
   logic [PW_W-1:0]     low_x;
   logic [PH_W-1:0]     low_y;
   logic [RECT_X_W-1:0] high_x;
   logic [RECT_Y_W-1:0] high_y;

   function automatic logic [PIX_W-1:0] fb_word(int unsigned addr);
      return shadow_fb.exists(addr) ? shadow_fb[addr] : '0;
   endfunction

   function automatic pixel_outcome_type predict_outcome(kind_type kind,
         logic [COORD_W-1:0] xr, logic [COORD_W-1:0] yr,
         logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
      pixel_outcome_type o;
      int x, y, px, py, w, h, pw, ph, span;
      int unsigned addr;
      logic [PIX_W-1:0] word;
      o = '0;
      o.status = STATUS_DONE;
      x = int'($signed(xr));
      y = int'($signed(yr));
      pw = int'(panel_w);
      ph = int'(panel_h);
      w = (pw > MAX_WIDTH) ? MAX_WIDTH : pw;
      h = (ph > MAX_HEIGHT) ? MAX_HEIGHT : ph;
      case (kind)
         KIND_DRAW: begin
            if (x < clip_xs || x >= clip_xe || y < clip_ys || y >= clip_ye) begin
               o.status = STATUS_CLIPPED;
            end else begin
               case (rot)
                  ROT_90:  begin px = pw - y - 1; py = x;          end
                  ROT_180: begin px = pw - x - 1; py = ph - y - 1; end
                  ROT_270: begin px = y;          py = ph - x - 1; end
                  default: begin px = x;          py = y;          end
               endcase
               if (px < 0 || py < 0 || px >= w || py >= h) begin
                  o.status = STATUS_OUTSIDE;
               end else begin
                  addr = py * w + px;
                  // byte-swapped rgb565
                  word = {g[4:2], b[7:3], r[7:3], g[7:5]};
                  if (fb_word(addr) == word) begin
                     o.status = STATUS_UNCHANGED;
                  end else begin
                     shadow_fb[addr] = word;
                     if (px < int'(low_x)) low_x = px[PW_W-1:0];
                     if (py < int'(low_y)) low_y = py[PH_W-1:0];
                     if (px > int'(high_x)) high_x = px[RECT_X_W-1:0];
                     if (py > int'(high_y)) high_y = py[RECT_Y_W-1:0];
                     o.status = STATUS_STORED;
                  end
               end
            end
         end
         KIND_FLUSH: begin
            if (!(low_x > high_x || low_y > high_y)) begin
               o.rect_valid = 1'b1;
               o.rect_x = low_x[RECT_X_W-1:0];
               o.rect_y = low_y[RECT_Y_W-1:0];
               span = int'(high_x) - int'(low_x) + 1;
               o.rect_w = span[RECT_W_W-1:0];
               span = int'(high_y) - int'(low_y) + 1;
               o.rect_h = span[RECT_H_W-1:0];
               low_x = panel_w;
               low_y = panel_h;
               high_x = '0;
               high_y = '0;
            end
         end
         default: begin
            if (x >= 0 && y >= 0 && x < w && y < h) o.pixel_word = fb_word(y * w + x);
         end
      endcase
      return o;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_outcome_type want;
      if (reset) begin
         outcome_q.delete();
         shadow_fb.delete();
         panel_w = 11'd800;
         panel_h = 10'd480;
         rot = ROT_0;
         clip_xs = -32768;
         clip_xe = 32767;
         clip_ys = -32768;
         clip_ye = 32767;
         low_x = '1;
         low_y = '1;
         high_x = '0;
         high_y = '0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("rsp beat with no request outstanding, status %0d", rsp_status);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", int'(want.status), int'(rsp_status));
               check_field("pixel_word", int'(want.pixel_word), int'(rsp_pixel_word));
               check_field("rect_valid", int'(want.rect_valid), int'(rsp_rect_valid));
               check_field("rect_x", int'(want.rect_x), int'(rsp_rect_x));
               check_field("rect_y", int'(want.rect_y), int'(rsp_rect_y));
               check_field("rect_w", int'(want.rect_w), int'(rsp_rect_w));
               check_field("rect_h", int'(want.rect_h), int'(rsp_rect_h));
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_PANEL_WIDTH:  panel_w = csr_wdata[PW_W-1:0];
               REG_PANEL_HEIGHT: panel_h = csr_wdata[PH_W-1:0];
               REG_ROTATION:     rot = csr_wdata[ROT_W-1:0];
               REG_CLIP_X_START: clip_xs = int'($signed(csr_wdata));
               REG_CLIP_X_END:   clip_xe = int'($signed(csr_wdata));
               REG_CLIP_Y_START: clip_ys = int'($signed(csr_wdata));
               REG_CLIP_Y_END:   clip_ye = int'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_valid && !req_stall && kind_type'(req_type) != KIND_NONE) begin
            outcome_q.push_back(predict_outcome(kind_type'(req_type), req_pos_x, req_pos_y,
                                                req_red, req_green, req_blue));
         end
      end
      outstanding = outcome_q.size();
   end

endmodule

### tb/rotated_pixel_writer_dirty_rect_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_pixel_writer_dirty_rect_unit_tb
// drives draw, flush and read requests through several panel, rotation and
// clip settings with random sender gaps and receiver stalls, including one
// long rsp hold-off; the checker predicts and compares every rsp beat
// ----------------------------------------------------------------------------
module rotated_pixel_writer_dirty_rect_unit_tb;
   import rpwdr_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_type = '0;
   logic [COORD_W-1:0]    req_pos_x = '0;
   logic [COORD_W-1:0]    req_pos_y = '0;
   logic [COLOR_W-1:0]    req_red = '0;
   logic [COLOR_W-1:0]    req_green = '0;
   logic [COLOR_W-1:0]    req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PIX_W-1:0]      rsp_pixel_word;
   logic                  rsp_rect_valid;
   logic [RECT_X_W-1:0]   rsp_rect_x;
   logic [RECT_Y_W-1:0]   rsp_rect_y;
   logic [RECT_W_W-1:0]   rsp_rect_w;
   logic [RECT_H_W-1:0]   rsp_rect_h;
   int                    fail_count;
   int                    outstanding;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int coord_span = 16;
   bit long_hold = 1'b0;
   int held = 0;

   always #5 clock = ~clock;

   rotated_pixel_writer_dirty_rect_unit dut (.*);

   rotated_pixel_writer_dirty_rect_checker pixel_check (.*);

   always @(negedge clock) begin
      if (long_hold && held < 400) begin
         rsp_stall <= 1'b1;
         held <= held + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(kind_type kind, int x, int y, int r, int g, int b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_pos_x <= x[COORD_W-1:0];
      req_pos_y <= y[COORD_W-1:0];
      req_red <= r[COLOR_W-1:0];
      req_green <= g[COLOR_W-1:0];
      req_blue <= b[COLOR_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      // requests of the unused kind leave no result, so give the pipe time
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_panel(int pw, int ph, logic [ROT_W-1:0] rotation,
                            int cxs, int cxe, int cys, int cye);
      write_reg(REG_PANEL_WIDTH, pw);
      write_reg(REG_PANEL_HEIGHT, ph);
      write_reg(REG_ROTATION, int'(rotation));
      write_reg(REG_CLIP_X_START, cxs);
      write_reg(REG_CLIP_X_END, cxe);
      write_reg(REG_CLIP_Y_START, cys);
      write_reg(REG_CLIP_Y_END, cye);
      coord_span = (pw > ph) ? pw : ph;
   endtask

   function automatic int pick_coord();
      if ($urandom_range(9) == 0) return int'($urandom_range(65535));
      return int'($urandom_range(coord_span + 6)) - 3;
   endfunction

   function automatic int pick_color();
      if ($urandom_range(3) == 0) return $urandom_range(1) ? 255 : 0;
      return int'($urandom_range(255));
   endfunction

   task automatic random_phase(int count, int idle_s, int idle_r);
      int pick;
      kind_type kind;
      send_idle_pct = idle_s;
      stall_pct = idle_r;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 66) kind = KIND_DRAW;
         else if (pick < 78) kind = KIND_FLUSH;
         else if (pick < 94) kind = KIND_READ;
         else kind = KIND_NONE;
         send_request(kind, pick_coord(), pick_coord(), pick_color(), pick_color(),
                      pick_color());
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: 800x480, no rotation, open clip
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      send_request(KIND_READ, 0, 0, 0, 0, 0);
      send_request(KIND_DRAW, 0, 0, 255, 255, 255);
      send_request(KIND_DRAW, 0, 0, 255, 255, 255);
      send_request(KIND_DRAW, 799, 479, 'h12, 'h34, 'h56);
      send_request(KIND_DRAW, 3, 3, 0, 0, 0);
      send_request(KIND_DRAW, 800, 0, 1, 2, 3);
      send_request(KIND_DRAW, 0, 480, 1, 2, 3);
      send_request(KIND_DRAW, -1, 5, 1, 2, 3);
      send_request(KIND_DRAW, -32768, -32768, 1, 2, 3);
      send_request(KIND_DRAW, 32767, 0, 1, 2, 3);
      send_request(KIND_DRAW, 0, 32767, 1, 2, 3);
      send_request(KIND_DRAW, 400, 200, 'hF8, 'h00, 'hF8);
      // dropped low color bits leave the word as it was
      send_request(KIND_DRAW, 400, 200, 'hFF, 'h03, 'hFF);
      send_request(KIND_READ, 799, 479, 0, 0, 0);
      send_request(KIND_READ, 400, 200, 0, 0, 0);
      send_request(KIND_READ, -1, 0, 0, 0, 0);
      send_request(KIND_READ, 800, 0, 0, 0, 0);
      send_request(KIND_READ, 0, 480, 0, 0, 0);
      send_request(KIND_NONE, 32767, -32768, 255, 255, 255);
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      send_request(KIND_DRAW, 0, 0, 0, 0, 0);
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      drain();

      // zero-sized panel: watermarks reset to the origin give a 1x1 rect
      set_panel(16, 8, ROT_0, -32768, 32767, -32768, 32767);
      send_request(KIND_DRAW, 15, 7, 255, 0, 0);
      drain();
      set_panel(0, 0, ROT_0, -32768, 32767, -32768, 32767);
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      send_request(KIND_FLUSH, 0, 0, 0, 0, 0);
      send_request(KIND_DRAW, 0, 0, 9, 9, 9);
      send_request(KIND_READ, 0, 0, 0, 0, 0);
      drain();

      set_panel(16, 8, ROT_0, -32768, 32767, -32768, 32767);
      random_phase(50, 0, 0);
      set_panel(16, 8, ROT_90, -2, 12, 1, 7);
      random_phase(50, 86, 0);
      set_panel(12, 20, ROT_180, 0, 12, -5, 15);
      random_phase(50, 0, 86);
      set_panel(9, 13, ROT_270, -32768, 32767, -32768, 32767);
      random_phase(50, 17, 17);

      // long rsp hold-off while requests keep coming
      set_panel(8, 4, ROT_0, -32768, 32767, -32768, 32767);
      long_hold = 1'b1;
      random_phase(50, 0, 0);

      set_panel(1, 1, ROT_180, -1, 1, -1, 1);
      random_phase(30, 17, 17);
      set_panel(1024, 512, ROT_90, -32768, 32767, -32768, 32767);
      random_phase(50, 17, 17);
      // register values beyond the store size saturate
      set_panel(2047, 1023, ROT_270, -32768, 32767, -32768, 32767);
      random_phase(30, 0, 0);
      set_panel(10, 6, ROT_180, 32767, -32768, -32768, 32767);
      random_phase(25, 17, 17);
      set_panel(16, 8, ROT_0, -32768, 32767, -32768, 32767);
      random_phase(50, 86, 86);

      if (fail_count == 0 && outstanding == 0) begin
         $display("rotated_pixel_writer_dirty_rect_unit_tb OK");
      end else begin
         $display("rotated_pixel_writer_dirty_rect_unit_tb NOT OK");
      end
      $finish;
   end

   // the timeout also covers the store clearing after reset
   initial begin
      #20_000_000;
      $display("rotated_pixel_writer_dirty_rect_unit_tb NOT OK");
      $finish;
   end

endmodule
